FILE: design/md5_pkg.sv
// ----------------------------------------------------------------------------
// MD5 package
// Shared types, step constants and round helper functions for the digest unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package md5_pkg;

  // Command carried by one input item.
  typedef enum logic [1:0] {
    CMD_DATA = 2'd0,
    CMD_LAST = 2'd1,
    CMD_END  = 2'd2,
    CMD_NOP  = 2'd3
  } md5_cmd_e;

  // Four 32-bit working or chaining words.
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } md5_abcd_t;

  localparam logic [31:0] MD5_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] MD5_S [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // Index of the message word used at a given step.
  function automatic logic [3:0] md5_g(input logic [5:0] step);
    logic [3:0] s4;
    logic [3:0] r;
    s4 = step[3:0];
    unique case (step[5:4])
      2'd0: r = s4;
      2'd1: r = 4'(s4 * 4'd5 + 4'd1);
      2'd2: r = 4'(s4 * 4'd3 + 4'd5);
      default: r = 4'(s4 * 4'd7);
    endcase
    return r;
  endfunction

  // Boolean round function.
  function automatic logic [31:0] md5_f(input logic [1:0] rnd, input logic [31:0] b,
                                        input logic [31:0] c, input logic [31:0] d);
    logic [31:0] r;
    unique case (rnd)
      2'd0: r = (b & c) | (~b & d);
      2'd1: r = (b & d) | (c & ~d);
      2'd2: r = b ^ c ^ d;
      default: r = c ^ (b | ~d);
    endcase
    return r;
  endfunction

  function automatic logic [31:0] md5_rotl(input logic [31:0] v, input logic [4:0] s);
    logic [63:0] t;
    t = {v, v} << s;
    return t[63:32];
  endfunction

endpackage

`default_nettype wire

FILE: design/md5_msg_buf.sv
// ----------------------------------------------------------------------------
// MD5 message block buffer
// Sixteen 32-bit words filled one byte at a time, little-endian within a word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module md5_msg_buf (
  input  wire logic        clk_i,
  input  wire logic        wr_en_i,
  input  wire logic [5:0]  wr_pos_i,
  input  wire logic [7:0]  wr_byte_i,
  input  wire logic [3:0]  rd_idx_i,
  output logic      [31:0] rd_word_o
);

  logic [3:0][7:0] words_q [16];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      words_q[wr_pos_i[5:2]][wr_pos_i[1:0]] <= wr_byte_i;
    end
  end

  assign rd_word_o = words_q[rd_idx_i];

endmodule

`default_nettype wire

FILE: design/md5_step_unit.sv
// ----------------------------------------------------------------------------
// MD5 step unit
// One compression step: round function, add, rotate and add into b.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module md5_step_unit (
  input  wire logic [5:0]          step_i,
  input  wire md5_pkg::md5_abcd_t  st_i,
  input  wire logic [31:0]         pre_i,
  output md5_pkg::md5_abcd_t       st_o
);

  logic [31:0] f;
  logic [31:0] sum;
  logic [31:0] rot;

  // pre_i already holds a + K + W for this step.
  always_comb begin
    f      = md5_pkg::md5_f(step_i[5:4], st_i.b, st_i.c, st_i.d);
    sum    = pre_i + f;
    rot    = md5_pkg::md5_rotl(sum, md5_pkg::MD5_S[{step_i[5:4], step_i[1:0]}]);
    st_o.a = st_i.d;
    st_o.b = st_i.b + rot;
    st_o.c = st_i.b;
    st_o.d = st_i.c;
  end

endmodule

`default_nettype wire

FILE: design/md5_message_digest_unit.sv
// ----------------------------------------------------------------------------
// MD5 message digest unit
// Streams message bytes, compresses each 64-byte block and emits the digest.
// ----------------------------------------------------------------------------
// A data byte is taken while the unit is idle; a byte that completes a
//   block holds off the input for the 64 compression steps on the shared step
//   unit and the fold, so no new byte is taken until that block is folded in.
// The digest follows the padding bytes (9 to 72), one or two compressions and
//   the load of the output register, and waits longer while the previous
//   digest is still waiting there.
// Reset: chaining words go to the MD5 initial values, byte position and bit
//   count clear, and the output register empties. The block buffer is not reset.
`timescale 1ns / 1ps
`default_nettype none

module md5_message_digest_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      digest_low_o,
  output logic [63:0]      digest_high_o
);

  // The sequencer waits for items in IDLE, inserts padding bytes in PAD, runs
  // the 64 compression steps in COMP, adds the working words into the chain
  // in FOLD, and hands the digest to the output register in DONE.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_FOLD,
    ST_DONE
  } state_e;

  // Padding runs in three phases: the 0x80 marker, zero fill up to byte 56,
  // and the eight bytes of the bit count.
  typedef enum logic [1:0] {
    PH_MARK,
    PH_ZERO,
    PH_LEN
  } phase_e;

  localparam md5_pkg::md5_abcd_t IV = '{
    a: 32'h67452301, b: 32'hefcdab89, c: 32'h98badcfe, d: 32'h10325476
  };
  localparam logic [5:0] LEN_POS = 6'd56;
  localparam logic [5:0] LAST_STEP = 6'd63;

  state_e             state_q;
  phase_e             phase_q;
  logic               pad_q;        // the message is being finished
  logic [5:0]         pos_q;
  logic [63:0]        bit_len_q;
  logic [5:0]         step_q;
  md5_pkg::md5_abcd_t chain_q;
  md5_pkg::md5_abcd_t work_q;
  logic [31:0]        pre_q;
  logic               out_valid_q;
  logic [63:0]        dig_low_q;
  logic [63:0]        dig_high_q;

  logic               buf_we;
  logic [7:0]         buf_byte;
  logic [7:0]         pad_byte;
  logic [5:0]         pos_inc;
  logic [5:0]         k_idx;
  logic [31:0]        pre_a;
  logic [31:0]        rd_word;
  logic [31:0]        pre_d;
  logic               in_fire;
  md5_pkg::md5_cmd_e  cmd;
  md5_pkg::md5_abcd_t step_out;

  assign in_ready_o    = (state_q == ST_IDLE);
  assign in_fire       = in_valid_i && in_ready_o;
  assign cmd           = md5_pkg::md5_cmd_e'(command_i);
  assign out_valid_o   = out_valid_q;
  assign digest_low_o  = dig_low_q;
  assign digest_high_o = dig_high_q;
  assign pos_inc       = pos_q + 6'd1;

  // Length bytes go out least significant first at positions 56 to 63.
  always_comb begin
    unique case (phase_q)
      PH_MARK: pad_byte = 8'h80;
      PH_LEN:  pad_byte = bit_len_q[{pos_q[2:0], 3'b000} +: 8];
      default: pad_byte = 8'h00;
    endcase
  end

  always_comb begin
    buf_we   = 1'b0;
    buf_byte = data_byte_i;
    if (state_q == ST_PAD) begin
      buf_we   = 1'b1;
      buf_byte = pad_byte;
    end else if (in_fire && (cmd == md5_pkg::CMD_DATA || cmd == md5_pkg::CMD_LAST)) begin
      buf_we = 1'b1;
    end
  end

  // The sum a + K + W of the next step is prepared and registered in pre_q. Outside
  // compression it is set up for step 0; inside, the next a is the current d.
  always_comb begin
    if (state_q == ST_COMP) begin
      k_idx = step_q + 6'd1;
      pre_a = work_q.d;
    end else begin
      k_idx = '0;
      pre_a = chain_q.a;
    end
    pre_d = pre_a + md5_pkg::MD5_K[k_idx] + rd_word;
  end

  md5_msg_buf u_buf (
    .clk_i     (clk_i),
    .wr_en_i   (buf_we),
    .wr_pos_i  (pos_q),
    .wr_byte_i (buf_byte),
    .rd_idx_i  (md5_pkg::md5_g(k_idx)),
    .rd_word_o (rd_word)
  );

  md5_step_unit u_step (
    .step_i (step_q),
    .st_i   (work_q),
    .pre_i  (pre_q),
    .st_o   (step_out)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_MARK;
      pad_q       <= 1'b0;
      pos_q       <= '0;
      bit_len_q   <= '0;
      step_q      <= '0;
      chain_q     <= IV;
      work_q      <= '0;
      pre_q       <= '0;
      out_valid_q <= 1'b0;
      dig_low_q   <= '0;
      dig_high_q  <= '0;
    end else begin
      pre_q <= pre_d;
      // In DONE the output register is reloaded below instead.
      if (out_valid_q && out_ready_i && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            unique case (cmd)
              md5_pkg::CMD_DATA, md5_pkg::CMD_LAST: begin
                pos_q     <= pos_inc;
                bit_len_q <= bit_len_q + 64'd8;
                pad_q     <= (cmd == md5_pkg::CMD_LAST);
                phase_q   <= PH_MARK;
                if (pos_inc == '0) begin
                  state_q <= ST_COMP;
                  work_q  <= chain_q;
                end else if (cmd == md5_pkg::CMD_LAST) begin
                  state_q <= ST_PAD;
                end
              end
              md5_pkg::CMD_END: begin
                pad_q   <= 1'b1;
                phase_q <= PH_MARK;
                state_q <= ST_PAD;
              end
              default: begin
              end
            endcase
          end
        end
        ST_PAD: begin
          pos_q <= pos_inc;
          if (phase_q != PH_LEN) begin
            phase_q <= (pos_inc == LEN_POS) ? PH_LEN : PH_ZERO;
          end
          if (pos_inc == '0) begin
            state_q <= ST_COMP;
            work_q  <= chain_q;
          end
        end
        ST_COMP: begin
          work_q <= step_out;
          step_q <= step_q + 6'd1;
          if (step_q == LAST_STEP) begin
            state_q <= ST_FOLD;
          end
        end
        ST_FOLD: begin
          chain_q.a <= chain_q.a + work_q.a;
          chain_q.b <= chain_q.b + work_q.b;
          chain_q.c <= chain_q.c + work_q.c;
          chain_q.d <= chain_q.d + work_q.d;
          if (!pad_q) begin
            state_q <= ST_IDLE;
          end else if (phase_q == PH_LEN) begin
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_PAD;
          end
        end
        ST_DONE: begin
          // Wait here until the output register is free or being emptied.
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            dig_low_q   <= {chain_q.b, chain_q.a};
            dig_high_q  <= {chain_q.d, chain_q.c};
            chain_q     <= IV;
            pos_q       <= '0;
            bit_len_q   <= '0;
            pad_q       <= 1'b0;
            phase_q     <= PH_MARK;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // The step counter only moves during compression and wraps back to zero.
  a_step_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_COMP |-> step_q == '0)
    else $error("step counter not at zero outside compression");

  // A compression always starts on a completed block.
  a_comp_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMP && step_q == '0) |-> pos_q == '0)
    else $error("compression started on a partial block");

  // A new digest appears only out of the hand-over state.
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("digest presented without finishing a message");

  // The digest is only handed over once the length bytes closed a block.
  a_done_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE |-> (pad_q && pos_q == '0 && phase_q == PH_LEN))
    else $error("finishing state reached before padding completed");

endmodule

`default_nettype wire

FILE: dv/md5_message_digest_unit_test.sv
// ----------------------------------------------------------------------------
// MD5 message digest unit testbench
// Streams byte messages into the unit under random handshake timing and checks
// every digest against an in-bench MD5 predictor. A short table of probes with
// well-known digests comes first. Random messages follow, mostly short, some
// with their lengths on the padding and block boundaries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module md5_message_digest_unit_test;

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
  } digest_t;

  // One row of the directed table. Where chk is set the digest is typed in,
  // otherwise it comes from the predictor.
  typedef struct packed {
    md5_pkg::md5_cmd_e cmd;
    logic [7:0]        data;
    logic              chk;
    logic [63:0]       lo;
    logic [63:0]       hi;
  } probe_row_t;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned LONG_HOLD   = 600;
  localparam int unsigned TAIL_CYCLES = 200;
  localparam int unsigned ITEM_TARGET = 550;
  localparam int unsigned DIGEST_GOAL = 16;

  // Well-known digests, bytes packed with the first one in bits 7 to 0.
  localparam logic [63:0] EMPTY_LO = 64'h04b2008fd98c1dd4;
  localparam logic [63:0] EMPTY_HI = 64'h7e42f8ec980980e9;
  localparam logic [63:0] A_LO     = 64'ha8b6f1c0b975c10c;
  localparam logic [63:0] A_HI     = 64'h61267769e299c331;
  localparam logic [63:0] ABC_LO   = 64'hb04fd23c98500190;
  localparam logic [63:0] ABC_HI   = 64'h727fe1287d3f96d6;

  localparam int NUM_PROBES = 14;
  localparam probe_row_t PROBES [NUM_PROBES] = '{
    {md5_pkg::CMD_END,  8'h00, 1'b1, EMPTY_LO, EMPTY_HI},  // empty message after reset
    {md5_pkg::CMD_LAST, 8'h61, 1'b1, A_LO,     A_HI},      // "a" as a single closing byte
    {md5_pkg::CMD_DATA, 8'h61, 1'b0, 128'h0},
    {md5_pkg::CMD_DATA, 8'h62, 1'b0, 128'h0},
    {md5_pkg::CMD_LAST, 8'h63, 1'b1, ABC_LO,   ABC_HI},    // "abc"
    {md5_pkg::CMD_NOP,  8'hff, 1'b0, 128'h0},              // ignored between messages
    {md5_pkg::CMD_DATA, 8'h00, 1'b0, 128'h0},
    {md5_pkg::CMD_DATA, 8'hff, 1'b0, 128'h0},
    {md5_pkg::CMD_NOP,  8'h00, 1'b0, 128'h0},              // ignored inside a message
    {md5_pkg::CMD_LAST, 8'h80, 1'b0, 128'h0},
    {md5_pkg::CMD_DATA, 8'h55, 1'b0, 128'h0},
    {md5_pkg::CMD_END,  8'haa, 1'b0, 128'h0},              // byte must be dropped on END
    {md5_pkg::CMD_NOP,  8'h55, 1'b0, 128'h0},
    {md5_pkg::CMD_END,  8'hff, 1'b1, EMPTY_LO, EMPTY_HI}   // empty again: chain restarted
  };

  // Additive constants and rotate amounts of the four rounds.
  localparam logic [31:0] SINE_ADD [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };
  localparam int unsigned ROT_LEFT [16] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };

  // Message lengths that sit on either side of the padding and block edges.
  localparam int unsigned EDGE_LENGTHS [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [1:0]  command_i   = md5_pkg::CMD_DATA;
  logic [7:0]  data_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] digest_low_o;
  logic [63:0] digest_high_o;

  md5_message_digest_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .digest_low_o (digest_low_o),
    .digest_high_o(digest_high_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor: the hash state as the unit should hold it after every accepted
  // item. The block buffer starts at zero, but every lane is overwritten
  // before a compression reads it, so its start value never matters.
  // --------------------------------------------------------------------------
  logic [31:0] chain_q [4];
  logic [31:0] block_q [16];
  logic [5:0]  fill_q;
  logic [63:0] nbits_q;

  digest_t digests_due [$];

  int unsigned errors          = 0;
  int unsigned items_sent      = 0;
  int unsigned ignored_sent    = 0;
  int unsigned digests_issued  = 0;
  int unsigned digests_checked = 0;
  int unsigned hold_asked      = 0;
  int unsigned cycle_count     = 0;

  function automatic logic [31:0] rol32(input logic [31:0] v, input int unsigned s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic void restart_chain();
    chain_q[0] = 32'h67452301;
    chain_q[1] = 32'hefcdab89;
    chain_q[2] = 32'h98badcfe;
    chain_q[3] = 32'h10325476;
    fill_q     = 6'd0;
    nbits_q    = 64'd0;
  endfunction

  // 64 steps over the current block, folded into the chaining words.
  function automatic void compress_block();
    logic [31:0] a, b, c, d, f, t;
    int unsigned rnd, w;
    a = chain_q[0];
    b = chain_q[1];
    c = chain_q[2];
    d = chain_q[3];
    for (int unsigned i = 0; i < 64; i++) begin
      rnd = i / 16;
      case (rnd)
        0: begin
          f = (b & c) | (~b & d);
          w = i % 16;
        end
        1: begin
          f = (b & d) | (c & ~d);
          w = (5 * i + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          w = (3 * i + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          w = (7 * i) % 16;
        end
      endcase
      t = a + f + block_q[w] + SINE_ADD[i];
      t = b + rol32(t, ROT_LEFT[rnd * 4 + i % 4]);
      a = d;
      d = c;
      c = b;
      b = t;
    end
    chain_q[0] += a;
    chain_q[1] += b;
    chain_q[2] += c;
    chain_q[3] += d;
  endfunction

  // Bytes land little-endian within each 32-bit block word.
  function automatic void absorb_byte(input logic [7:0] v);
    block_q[fill_q[5:2]][fill_q[1:0] * 8 +: 8] = v;
    fill_q = fill_q + 6'd1;
    if (fill_q == 6'd0) begin
      compress_block();
    end
  endfunction

  // Advances the predicted state by one item; returns 1 when a digest is due.
  function automatic bit md5_feed(input md5_pkg::md5_cmd_e cmd, input logic [7:0] b,
                                  output digest_t dig);
    logic [63:0] len;
    dig = '0;
    if (cmd == md5_pkg::CMD_NOP) begin
      return 1'b0;
    end
    if (cmd != md5_pkg::CMD_END) begin
      absorb_byte(b);
      nbits_q += 64'd8;
      if (cmd == md5_pkg::CMD_DATA) begin
        return 1'b0;
      end
    end
    // Padding: a single one bit, zeros up to 56 mod 64, then the bit count.
    len = nbits_q;
    absorb_byte(8'h80);
    while (fill_q != 6'd56) begin
      absorb_byte(8'h00);
    end
    for (int i = 0; i < 8; i++) begin
      absorb_byte(len[8 * i +: 8]);
    end
    dig.lo = {chain_q[1], chain_q[0]};
    dig.hi = {chain_q[3], chain_q[2]};
    restart_chain();
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Sender side. Every task is entered and left at a rising edge, so valid
  // and payload only ever change there and get one assignment per edge.
  // --------------------------------------------------------------------------

  // Offers one item, holds it until accepted and records what it should cause.
  // A typed digest, where given, replaces the predicted one as the expectation.
  task automatic push_item(input md5_pkg::md5_cmd_e c, input logic [7:0] b,
                           input logic typed, input digest_t typed_dig);
    digest_t calc;
    in_valid_i  <= 1'b1;
    command_i   <= c;
    data_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    if (md5_feed(c, b, calc)) begin
      digests_due.push_back(typed ? typed_dig : calc);
      digests_issued++;
    end
    if (c == md5_pkg::CMD_NOP) begin
      ignored_sent++;
    end else begin
      items_sent++;
    end
  endtask

  // Mostly back to back or a short gap, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic sender_idle(input int unsigned n);
    if (n != 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Drops valid and waits until every predicted digest has been taken.
  task automatic wait_for_digests();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (digests_due.size() != 0);
  endtask

  // Most messages are short; some sit on a padding or block edge and a few
  // span several blocks. This keeps the compression busy without long runs.
  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return $urandom_range(0, 6);
    if (r < 87) return $urandom_range(7, 70);
    if (r < 97) return EDGE_LENGTHS[$urandom_range(0, 9)];
    return $urandom_range(129, 260);
  endfunction

  // One whole message with random bytes. It closes either on its last byte
  // or with a separate end item; an empty message always takes the latter.
  // Unused commands are scattered in now and then as noise.
  task automatic send_message(input int unsigned len, input bit close_on_byte,
                              input bit back_to_back);
    md5_pkg::md5_cmd_e c;
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 3) begin
        push_item(md5_pkg::CMD_NOP, 8'($urandom()), 1'b0, '0);
        sender_idle(back_to_back ? 0 : pick_gap());
      end
      c = (close_on_byte && i == len - 1) ? md5_pkg::CMD_LAST : md5_pkg::CMD_DATA;
      push_item(c, 8'($urandom()), 1'b0, '0);
      sender_idle(back_to_back ? 0 : pick_gap());
    end
    if (!close_on_byte || len == 0) begin
      push_item(md5_pkg::CMD_END, 8'($urandom()), 1'b0, '0);
      sender_idle(back_to_back ? 0 : pick_gap());
    end
  endtask

  initial begin
    restart_chain();
    for (int i = 0; i < 16; i++) begin
      block_q[i] = 32'h0;
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed probes: known digests, both byte extremes, every command.
    for (int i = 0; i < NUM_PROBES; i++) begin
      push_item(PROBES[i].cmd, PROBES[i].data, PROBES[i].chk,
                {PROBES[i].lo, PROBES[i].hi});
      sender_idle(pick_gap());
    end

    // The sender holds back until the unit has delivered everything it owes.
    wait_for_digests();

    // Random messages. Once, early on, the receiver stops taking digests for
    // a long stretch while a burst of tiny messages keeps arriving, so the
    // output stage fills and the unit has to stall its input.
    while (items_sent < ITEM_TARGET || digests_issued < DIGEST_GOAL) begin
      if (hold_asked == 0 && digests_issued >= 12) begin
        hold_asked = 1;
        for (int k = 0; k < 6; k++) begin
          send_message($urandom_range(0, 1), 1'($urandom_range(0, 1)), 1'b1);
        end
      end
      send_message(pick_length(), 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
    end

    wait_for_digests();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d message items and %0d ignored commands; %0d digests checked.",
             items_sent, ignored_sent, digests_checked);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver side: runs of ready, short and long stalls, and the one long
  // hold-off that the sender asks for through hold_asked.
  // --------------------------------------------------------------------------
  initial begin : digest_sink
    int unsigned served;
    int unsigned r;
    served = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (served != hold_asked) begin
        served = hold_asked;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          out_ready_i <= 1'b1;
          repeat ($urandom_range(1, 30)) @(posedge clk_i);
        end else if (r < 90) begin
          out_ready_i <= 1'b0;
          repeat ($urandom_range(1, 4)) @(posedge clk_i);
        end else begin
          out_ready_i <= 1'b0;
          repeat ($urandom_range(20, 80)) @(posedge clk_i);
        end
      end
    end
  end

  // Every digest that leaves the unit is matched against the oldest one due.
  always @(posedge clk_i) begin : digest_check
    digest_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (digests_due.size() == 0) begin
        $display("%0t ns: expected no digest, got low %h high %h",
                 $time, digest_low_o, digest_high_o);
        errors++;
      end else begin
        want = digests_due.pop_front();
        if (digest_low_o !== want.lo) begin
          $display("%0t ns: digest_low expected %h, got %h", $time, want.lo, digest_low_o);
          errors++;
        end
        if (digest_high_o !== want.hi) begin
          $display("%0t ns: digest_high expected %h, got %h", $time, want.hi, digest_high_o);
          errors++;
        end
      end
      digests_checked++;
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t ns: cycle limit reached with %0d digests outstanding",
               $time, digests_due.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule
